/* hdl/irs_pkg.sv */
// ----------------------------------------------------------------------------
// irs_pkg
// Shared constants, types and helpers for the integer to radix string block.
// ----------------------------------------------------------------------------
package irs_pkg;

    localparam int VALUE_BITS_DEF = 32;

    localparam int RADIX_W = 6;
    localparam int CHAR_W  = 7;
    localparam int LEN_W   = 6;
    localparam int APB_DATA_W = 32;
    localparam int PADDR_W    = 3;

    localparam logic [PADDR_W-1:0] ADDR_RADIX = 3'd0;

    localparam logic [RADIX_W-1:0] RADIX_RESET = 6'd10;
    localparam logic [RADIX_W-1:0] RADIX_MIN   = 6'd2;
    localparam logic [RADIX_W-1:0] RADIX_MAX   = 6'd36;
    localparam logic [RADIX_W-1:0] DIGIT_DEC_MAX = 6'd9;

    localparam logic [CHAR_W-1:0] CH_ZERO  = 7'h30;
    localparam logic [CHAR_W-1:0] CH_A     = 7'h61;
    localparam logic [CHAR_W-1:0] CH_MINUS = 7'h2d;
    localparam logic [CHAR_W-1:0] CH_NUL   = 7'h00;
    localparam logic [CHAR_W-1:0] DIGIT_TEN = 7'd10;

    typedef struct packed {
        logic busy;
        logic done;
    } t_div_stat;

    function automatic logic [CHAR_W-1:0] digit_char(input logic [RADIX_W-1:0] d);
        logic [CHAR_W-1:0] dx;
        dx = {1'b0, d};
        if (d <= DIGIT_DEC_MAX) begin
            return CH_ZERO + dx;
        end else begin
            return CH_A + dx - DIGIT_TEN;
        end
    endfunction

endpackage

/* hdl/irs_div.sv */
// ----------------------------------------------------------------------------
// irs_div
// Restoring divider, one quotient bit per cycle, small divisor.
// ----------------------------------------------------------------------------
module irs_div #(
    parameter int VALUE_BITS = irs_pkg::VALUE_BITS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [VALUE_BITS-1:0]       i_dividend,
    input  logic [irs_pkg::RADIX_W-1:0] i_divisor,
    output irs_pkg::t_div_stat          o_stat,
    output logic [VALUE_BITS-1:0]       o_quotient,
    output logic [irs_pkg::RADIX_W-1:0] o_remainder
);

    localparam int CNT_W = $clog2(VALUE_BITS);
    localparam int RW    = irs_pkg::RADIX_W;

    logic [VALUE_BITS-1:0] r_quo;
    logic [RW-1:0]         r_rem;
    logic [CNT_W-1:0]      r_cnt;
    logic                  r_busy;
    logic                  r_done;

    logic [RW:0]   w_trial;
    logic [RW:0]   w_div;
    logic [RW:0]   w_diff;
    logic          w_ge;
    logic [RW-1:0] n_rem;

    assign w_trial = {r_rem, r_quo[VALUE_BITS-1]};
    assign w_div   = {1'b0, i_divisor};
    assign w_ge    = (w_trial >= w_div);
    assign w_diff  = w_trial - w_div;
    assign n_rem   = w_ge ? w_diff[RW-1:0] : w_trial[RW-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= r_busy && (r_cnt == '0);
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(VALUE_BITS - 1);
            end else if (r_busy) begin
                r_cnt <= r_cnt - CNT_W'(1);
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_dividend;
            r_rem <= '0;
        end else if (r_busy) begin
            r_quo <= {r_quo[VALUE_BITS-2:0], w_ge};
            r_rem <= n_rem;
        end
    end

    assign o_stat.busy = r_busy;
    assign o_stat.done = r_done;
    assign o_quotient  = r_quo;
    assign o_remainder = r_rem;

endmodule

/* hdl/integer_to_radix_string.sv */
// Sequence: each digit is produced by the shared bit-serial divider and kept
// in the digit store; then a minus sign, if any, and each digit character are emitted.
// Throughput: one value at a time; a new value is taken only after the last
// character of the previous one has been loaded for output. An invalid radix
// yields a single error transfer instead of digits.
// Reset: synchronous, active low; radix returns to 10, control state clears,
// the digit store is not cleared.
// ----------------------------------------------------------------------------
// integer_to_radix_string
// Converts a signed integer to ASCII text in a configurable base.
// ----------------------------------------------------------------------------
module integer_to_radix_string #(
    parameter int VALUE_BITS = irs_pkg::VALUE_BITS_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [irs_pkg::PADDR_W-1:0]    paddr,
    input  logic [irs_pkg::APB_DATA_W-1:0] pwdata,
    output logic [irs_pkg::APB_DATA_W-1:0] prdata,
    output logic                           pready,
    input  logic                           i_in_valid,
    output logic                           o_in_stall,
    input  logic signed [VALUE_BITS-1:0]   i_value,
    output logic                           o_out_valid,
    input  logic                           i_out_stall,
    output logic [irs_pkg::CHAR_W-1:0]     o_char_code,
    output logic                           o_last,
    output logic                           o_error,
    output logic [irs_pkg::LEN_W-1:0]      o_length
);

    localparam int RW = irs_pkg::RADIX_W;
    localparam int LW = irs_pkg::LEN_W;
    localparam int CHW = irs_pkg::CHAR_W;
    localparam int AW = $clog2(VALUE_BITS);
    localparam int CW = $clog2(VALUE_BITS + 1);
    localparam int TW = ((CW + 1) > LW) ? (CW + 1) : LW;
    localparam logic [CW-1:0] CNT_ONE = CW'(1);
    localparam logic [CW-1:0] CNT_LAST = CW'(VALUE_BITS - 1);
    localparam logic [VALUE_BITS-1:0] VAL_ONE = VALUE_BITS'(1);

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_DIV   = 6'b000010,
        S_SIGN  = 6'b000100,
        S_FETCH = 6'b001000,
        S_EMIT  = 6'b010000,
        S_ERR   = 6'b100000
    } t_state;

    t_state r_state, n_state;
    logic [RW-1:0] r_radix;
    logic [CW-1:0] r_count, n_count;
    logic          r_neg, n_neg;
    logic [LW-1:0] r_len, n_len;
    logic [RW-1:0] r_rd_data;
    logic [RW-1:0] r_digit_mem [VALUE_BITS];

    logic           r_out_valid;
    logic [CHW-1:0] r_char;
    logic           r_last;
    logic           r_err;
    logic [LW-1:0]  r_olen;

    logic           w_out_load;
    logic [CHW-1:0] w_char;
    logic           w_last;
    logic           w_err;
    logic [LW-1:0]  w_olen;

    logic                  w_accept;
    logic                  w_radix_ok;
    logic                  w_neg;
    logic [VALUE_BITS-1:0] w_uval;
    logic [VALUE_BITS-1:0] w_mag;
    logic                  w_more;
    logic                  w_out_free;
    logic                  w_fin;
    logic [CW-1:0]         w_cnt_inc;
    logic [CW-1:0]         w_cnt_dec;
    logic [TW-1:0]         w_total;
    logic [AW-1:0]         w_rd_addr;
    logic [AW-1:0]         w_wr_addr;
    logic                  w_mem_we;

    logic                  w_div_start;
    logic [VALUE_BITS-1:0] w_div_dividend;
    irs_pkg::t_div_stat    w_div_stat;
    logic [VALUE_BITS-1:0] w_div_quo;
    logic [RW-1:0]         w_div_rem;

    // configuration
    assign pready = 1'b1;
    assign prdata = (paddr == irs_pkg::ADDR_RADIX) ?
                    {{(irs_pkg::APB_DATA_W - RW){1'b0}}, r_radix} : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_radix <= irs_pkg::RADIX_RESET;
        end else if (psel && penable && pwrite && pready &&
                     (paddr == irs_pkg::ADDR_RADIX)) begin
            r_radix <= pwdata[RW-1:0];
        end
    end

    assign w_radix_ok = (r_radix >= irs_pkg::RADIX_MIN) && (r_radix <= irs_pkg::RADIX_MAX);
    assign w_accept   = i_in_valid && (r_state == S_IDLE);
    assign o_in_stall = (r_state != S_IDLE);

    assign w_uval = $unsigned(i_value);
    assign w_neg  = w_uval[VALUE_BITS-1];
    assign w_mag  = w_neg ? ((w_uval ^ {VALUE_BITS{1'b1}}) + VAL_ONE) : w_uval;

    assign w_cnt_inc  = r_count + CNT_ONE;
    assign w_cnt_dec  = r_count - CNT_ONE;
    assign w_total    = TW'(w_cnt_inc) + TW'(r_neg);
    assign w_more     = (w_div_quo != '0) && (r_count < CNT_LAST);
    assign w_out_free = !r_out_valid || !i_out_stall;
    assign w_fin      = (r_count == CNT_ONE);

    assign w_div_start    = (w_accept && w_radix_ok) ||
                            ((r_state == S_DIV) && w_div_stat.done && w_more);
    assign w_div_dividend = (r_state == S_IDLE) ? w_mag : w_div_quo;
    assign w_mem_we       = (r_state == S_DIV) && w_div_stat.done;
    assign w_wr_addr      = r_count[AW-1:0];
    assign w_rd_addr      = w_cnt_dec[AW-1:0];

    irs_div #(
        .VALUE_BITS (VALUE_BITS)
    ) u_div (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (w_div_start),
        .i_dividend  (w_div_dividend),
        .i_divisor   (r_radix),
        .o_stat      (w_div_stat),
        .o_quotient  (w_div_quo),
        .o_remainder (w_div_rem)
    );

    // digit store
    always_ff @(posedge i_clk) begin
        if (w_mem_we) begin
            r_digit_mem[w_wr_addr] <= w_div_rem;
        end
        r_rd_data <= r_digit_mem[w_rd_addr];
    end

    always_comb begin
        n_state    = r_state;
        n_count    = r_count;
        n_neg      = r_neg;
        n_len      = r_len;
        w_out_load = 1'b0;
        w_char     = irs_pkg::CH_NUL;
        w_last     = 1'b0;
        w_err      = 1'b0;
        w_olen     = '0;
        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_count = '0;
                    if (w_radix_ok) begin
                        n_neg   = w_neg;
                        n_state = S_DIV;
                    end else begin
                        n_state = S_ERR;
                    end
                end
            end
            S_DIV: begin
                if (w_div_stat.done) begin
                    n_count = w_cnt_inc;
                    n_len   = w_total[LW-1:0];
                    if (!w_more) begin
                        n_state = r_neg ? S_SIGN : S_FETCH;
                    end
                end
            end
            S_SIGN: begin
                if (w_out_free) begin
                    w_out_load = 1'b1;
                    w_char     = irs_pkg::CH_MINUS;
                    n_state    = S_FETCH;
                end
            end
            S_FETCH: begin
                n_state = S_EMIT;
            end
            S_EMIT: begin
                if (w_out_free) begin
                    w_out_load = 1'b1;
                    w_char     = irs_pkg::digit_char(r_rd_data);
                    w_last     = w_fin;
                    w_olen     = w_fin ? r_len : '0;
                    n_count    = w_cnt_dec;
                    n_state    = w_fin ? S_IDLE : S_FETCH;
                end
            end
            S_ERR: begin
                if (w_out_free) begin
                    w_out_load = 1'b1;
                    w_last     = 1'b1;
                    w_err      = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_neg       <= 1'b0;
            r_len       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_neg   <= n_neg;
            r_len   <= n_len;
            if (w_out_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // output transfer register
    always_ff @(posedge i_clk) begin
        if (w_out_load) begin
            r_char <= w_char;
            r_last <= w_last;
            r_err  <= w_err;
            r_olen <= w_olen;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_char_code = r_char;
    assign o_last      = r_last;
    assign o_error     = r_err;
    assign o_length    = r_olen;

`ifndef NO_ASSERTIONS
    a_div_start_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_start |-> !w_div_stat.busy)
        else $error("divider restarted while busy");

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(VALUE_BITS))
        else $error("digit count out of range");

    a_last_empties: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_out_load && w_last && !w_err) |=> (r_count == '0) && (r_state == S_IDLE))
        else $error("digits left after last character");

    a_error_form: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_error) |-> (o_last && (o_char_code == irs_pkg::CH_NUL) &&
                                      (o_length == '0)))
        else $error("malformed error transfer");
`endif

endmodule

/* dv/integer_to_radix_string_tb.sv */
// ----------------------------------------------------------------------------
// integer_to_radix_string_tb
// Checks the radix text converter against a behavioral prediction of its
// character stream. Values go in through the valid/stall input channel. The
// radix is set over the APB port between phases: reset default, both
// extremes, out-of-range codes and random bases. Each output transfer is
// compared field by field with the oldest predicted character. Sender gaps and
// receiver stalls change from phase to phase.
// ----------------------------------------------------------------------------
module integer_to_radix_string_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int VBITS      = 32;
    localparam int QUIET_MAX  = 20000;
    localparam int TAIL_WAIT  = 40;
    localparam int SETTLE_GAP = 8;

    typedef struct packed {
        logic [irs_pkg::CHAR_W-1:0] ch;
        logic                       last;
        logic                       err;
        logic [irs_pkg::LEN_W-1:0]  len;
    } t_text_char;

    class t_radix_text_board;
        t_text_char                  pending[$];
        logic [irs_pkg::RADIX_W-1:0] radix;
        int n_values;
        int n_chars;
        int n_bad;

        function new();
            radix = irs_pkg::RADIX_RESET;
        endfunction

        function void note_value(logic signed [VBITS-1:0] v);
            logic [VBITS-1:0]            mag;
            logic [irs_pkg::RADIX_W-1:0] digits[$];
            int unsigned                 rdx;
            int                          total;
            logic [irs_pkg::RADIX_W-1:0] d;
            t_text_char                  c;
            n_values++;
            rdx = 32'(radix);
            if (radix < irs_pkg::RADIX_MIN || radix > irs_pkg::RADIX_MAX) begin
                pending.push_back('{irs_pkg::CH_NUL, 1'b1, 1'b1, '0});
                return;
            end
            mag = v[VBITS-1] ? VBITS'(-v) : v;
            do begin
                digits.push_back(irs_pkg::RADIX_W'(mag % rdx));
                mag = mag / rdx;
            end while (mag != 0);
            total = digits.size() + (v[VBITS-1] ? 1 : 0);
            if (v[VBITS-1])
                pending.push_back('{irs_pkg::CH_MINUS, 1'b0, 1'b0, '0});
            for (int i = digits.size() - 1; i >= 0; i--) begin
                d = digits[i];
                c.ch   = (d <= 9) ? irs_pkg::CH_ZERO + irs_pkg::CHAR_W'(d)
                                  : irs_pkg::CH_A + irs_pkg::CHAR_W'(d) -
                                    irs_pkg::CHAR_W'(10);
                c.last = (i == 0);
                c.err  = 1'b0;
                c.len  = (i == 0) ? irs_pkg::LEN_W'(total) : '0;
                pending.push_back(c);
            end
        endfunction

        function void flag(string msg);
            n_bad++;
            if (n_bad <= 10)
                $display("MISMATCH: %s", msg);
        endfunction

        function void check_char(t_text_char got);
            t_text_char want;
            n_chars++;
            if (pending.size() == 0) begin
                flag($sformatf("unexpected char %h last %b err %b len %0d",
                               got.ch, got.last, got.err, got.len));
                return;
            end
            want = pending.pop_front();
            if (got.ch !== want.ch || got.last !== want.last ||
                got.err !== want.err || got.len !== want.len)
                flag($sformatf("char %0d: expected %h/%b/%b/%0d, got %h/%b/%b/%0d",
                               n_chars, want.ch, want.last, want.err, want.len,
                               got.ch, got.last, got.err, got.len));
        endfunction
    endclass

    logic                             i_clk;
    logic                             i_rst_n     = 1'b0;
    logic                             psel        = 1'b0;
    logic                             penable     = 1'b0;
    logic                             pwrite      = 1'b0;
    logic [irs_pkg::PADDR_W-1:0]      paddr       = '0;
    logic [irs_pkg::APB_DATA_W-1:0]   pwdata      = '0;
    logic [irs_pkg::APB_DATA_W-1:0]   prdata;
    logic                             pready;
    logic                             i_in_valid  = 1'b0;
    logic                             o_in_stall;
    logic signed [VBITS-1:0]          i_value     = '0;
    logic                             o_out_valid;
    logic                             i_out_stall = 1'b0;
    logic [irs_pkg::CHAR_W-1:0]       o_char_code;
    logic                             o_last;
    logic                             o_error;
    logic [irs_pkg::LEN_W-1:0]        o_length;

    t_radix_text_board board;
    int send_pct = 0;
    int recv_pct = 0;
    int n_radix_writes = 0;
    int quiet_cycles = 0;

    integer_to_radix_string #(.VALUE_BITS(VBITS)) u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_value    (i_value),
        .o_out_valid(o_out_valid),
        .i_out_stall(i_out_stall),
        .o_char_code(o_char_code),
        .o_last     (o_last),
        .o_error    (o_error),
        .o_length   (o_length)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        i_out_stall <= (recv_pct > 0) && ($urandom_range(99) < recv_pct);
    end

    // transfer monitor and watchdog
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            quiet_cycles++;
            if (i_in_valid && !o_in_stall) begin
                board.note_value(i_value);
                quiet_cycles = 0;
            end
            if (o_out_valid && !i_out_stall) begin
                board.check_char('{o_char_code, o_last, o_error, o_length});
                quiet_cycles = 0;
            end
            if (quiet_cycles >= QUIET_MAX) begin
                $display("timeout: no transfer for %0d cycles, %0d chars outstanding",
                         quiet_cycles, board.pending.size());
                $display("integer_to_radix_string_tb: done, errors");
                $finish;
            end
        end
    end

    task automatic push_value(input logic signed [VBITS-1:0] v);
        while (send_pct > 0 && $urandom_range(99) < send_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_value    <= v;
        do @(posedge i_clk); while (o_in_stall);
    endtask

    task automatic settle();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (board.pending.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_GAP) @(posedge i_clk);
    endtask

    task automatic write_radix(input logic [irs_pkg::RADIX_W-1:0] r);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= irs_pkg::ADDR_RADIX;
        pwdata  <= irs_pkg::APB_DATA_W'(r);
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        board.radix = r;
        n_radix_writes++;
    endtask

    task automatic send_list(input logic signed [VBITS-1:0] vals[$]);
        foreach (vals[i])
            push_value(vals[i]);
        settle();
    endtask

    task automatic set_pressure(input int mode);
        case (mode)
            0: begin send_pct = 0;  recv_pct = 0;  end
            1: begin send_pct = 75; recv_pct = 0;  end
            2: begin send_pct = 0;  recv_pct = 75; end
            default: begin send_pct = 23; recv_pct = 23; end
        endcase
    endtask

    function automatic logic signed [VBITS-1:0] pick_value(
        input logic [irs_pkg::RADIX_W-1:0] r);
        int unsigned rdx;
        logic [VBITS-1:0] p;
        logic signed [VBITS-1:0] v;
        int sel;
        rdx = (r < irs_pkg::RADIX_MIN || r > irs_pkg::RADIX_MAX) ? 10 : 32'(r);
        sel = $urandom_range(99);
        if (sel < 40) begin
            v = $urandom;
        end else if (sel < 60) begin
            v = $urandom_range(2 * rdx);
        end else if (sel < 80) begin
            // around a power of the base
            p = 1;
            repeat ($urandom_range(1, 31))
                if (p <= 32'h7fff_ffff / rdx)
                    p = p * rdx;
            v = p - $urandom_range(1);
        end else if (sel < 90) begin
            case ($urandom_range(3))
                0: v = 32'sh7fff_ffff;
                1: v = 32'sh8000_0000;
                2: v = 0;
                default: v = 1;
            endcase
        end else begin
            v = $urandom >> $urandom_range(31);
        end
        if (sel >= 40 && sel < 80 && $urandom_range(1))
            v = -v;
        return v;
    endfunction

    initial begin
        logic [irs_pkg::RADIX_W-1:0] r;
        int n;
        board = new();
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset base, then base extremes and out-of-range codes
        send_list('{0, 1, -1, 9, 10, -10, 32'sh7fff_ffff, 32'sh8000_0000});
        write_radix(6'd2);
        send_list('{0, 1, -1, 32'sh7fff_ffff, 32'sh8000_0000});
        write_radix(irs_pkg::RADIX_MAX);
        send_list('{35, 36, -35, 32'sh7fff_ffff, 32'sh8000_0000});
        write_radix(6'd0);
        send_list('{5});
        write_radix(6'd1);
        send_list('{-3});
        write_radix(6'd37);
        send_list('{7});
        write_radix(6'd63);
        send_list('{0});

        for (int ph = 0; ph < 13; ph++) begin
            case (ph)
                0: r = 6'd2;
                1: r = 6'd16;
                2: r = 6'd10;
                3: r = 6'd36;
                4: r = 6'd3;
                5: r = 6'd8;
                6: r = $urandom_range(1) ? irs_pkg::RADIX_W'($urandom_range(1))
                                         : irs_pkg::RADIX_W'($urandom_range(37, 63));
                7: r = 6'd35;
                8: r = 6'd7;
                9: r = 6'd2;
                10: r = 6'd5;
                11: r = 6'd10;
                default: r = irs_pkg::RADIX_W'($urandom_range(2, 36));
            endcase
            set_pressure(ph % 4);
            write_radix(r);
            n = (ph == 6) ? 8 : 30;
            repeat (n)
                push_value(pick_value(r));
            settle();
        end

        set_pressure(0);
        repeat (TAIL_WAIT) @(posedge i_clk);
        $display("covered %0d values over %0d radix writes, %0d characters compared",
                 board.n_values, n_radix_writes, board.n_chars);
        $display("%0d mismatches, %0d characters never seen",
                 board.n_bad, board.pending.size());
        if (board.n_bad == 0 && board.pending.size() == 0) begin
            $display("integer_to_radix_string_tb: done, clean");
        end else begin
            $display("integer_to_radix_string_tb: done, errors");
        end
        $finish;
    end

endmodule

/* integer_to_radix_string.f */
hdl/irs_pkg.sv
hdl/irs_div.sv
hdl/integer_to_radix_string.sv
dv/integer_to_radix_string_tb.sv
